/* design/aabbxf_pkg.sv */
// ----------------------------------------------------------------------------
// aabbxf_pkg
// Shared types and constants of the transformed bounding box block.
// ----------------------------------------------------------------------------
package aabbxf_pkg;

    // Default number of fraction bits of the fixed-point format
    localparam int FRAC_BITS_DEF = 16;

    localparam int COORD_W = 32;
    localparam int CFG_W   = 64;
    localparam int CFG_IDX_W = 3;
    localparam int NUM_FIELDS = 6;
    localparam int TDATA_W = NUM_FIELDS * COORD_W;

    typedef logic signed [COORD_W-1:0] t_coord;

    // Register indexes of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_XROW_XY = 3'd0,
        CFG_XROW_ZT = 3'd1,
        CFG_YROW_XY = 3'd2,
        CFG_YROW_ZT = 3'd3,
        CFG_ZROW_XY = 3'd4,
        CFG_ZROW_ZT = 3'd5
    } t_cfg_idx;

endpackage

/* design/aabb_affine_transform.sv */
// ----------------------------------------------------------------------------
// aabb_affine_transform
// Transforms an axis-aligned box by an affine 3x4 matrix and returns the
// axis-aligned bounds of the result, signed fixed point.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake                    payload
//  s_axis    in   i_s_axis_tvalid/o_s_axis_tready  min x,y,z then max x,y,z
//  m_axis    out  o_m_axis_tvalid/i_m_axis_tready  min x,y,z then max x,y,z
//  cfg       in   i_cfg_we                      i_cfg_idx, i_cfg_data
//
// One box per cycle while the output is ready; each box passes in order through
// the input register, widening, products, per-axis min/max, sum and saturate.
// The rate is set by the product stage: eighteen 32x32 multipliers, two per
// coefficient, work in parallel on every beat.
// A stalled output holds the whole pipeline; empty stages still fill, so the
// pipeline holds up to five beats while the output waits.
// Reset clears the stage valid bits and loads the identity matrix.
//
// The bounds of the eight corners separate per axis: floor shift and
// saturation are monotone, so each row's minimum is the saturated sum of the
// smaller shifted product of each coefficient and the translation.
// ----------------------------------------------------------------------------
module aabb_affine_transform #(
    parameter int FRAC_BITS = aabbxf_pkg::FRAC_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // fields, low bit up: in_min_x, in_min_y, in_min_z, in_max_x, in_max_y, in_max_z
    input  logic [aabbxf_pkg::TDATA_W-1:0]     i_s_axis_tdata,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // fields, low bit up: out_min_x, out_min_y, out_min_z,
    //                     out_max_x, out_max_y, out_max_z
    output logic [aabbxf_pkg::TDATA_W-1:0]     o_m_axis_tdata,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    input  logic                               i_cfg_we,
    input  logic [aabbxf_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [aabbxf_pkg::CFG_W-1:0]       i_cfg_data
);

    localparam int CW    = aabbxf_pkg::COORD_W;
    localparam int PW    = 2 * CW;                // full product width
    localparam int SH_W  = PW - FRAC_BITS;        // product after the shift
    localparam int SUM_W = SH_W + 2;              // three products plus translation
    localparam int DEPTH_BIAS = ((1 << FRAC_BITS) + 50) / 100;
    localparam logic signed [CW:0] BIAS_E = (CW+1)'(DEPTH_BIAS);
    localparam logic [aabbxf_pkg::CFG_W-1:0] ONE_LO = aabbxf_pkg::CFG_W'(1) << FRAC_BITS;
    localparam logic [aabbxf_pkg::CFG_W-1:0] ONE_HI = ONE_LO << CW;
    localparam aabbxf_pkg::t_coord S32_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam aabbxf_pkg::t_coord S32_MIN = {1'b1, {(CW-1){1'b0}}};

    // ---------------- configuration ----------------
    logic [aabbxf_pkg::CFG_W-1:0] r_xrow_xy, r_xrow_zt, r_yrow_xy;
    logic [aabbxf_pkg::CFG_W-1:0] r_yrow_zt, r_zrow_xy, r_zrow_zt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xrow_xy <= ONE_LO;
            r_xrow_zt <= '0;
            r_yrow_xy <= ONE_HI;
            r_yrow_zt <= '0;
            r_zrow_xy <= '0;
            r_zrow_zt <= ONE_LO;
        end else if (i_cfg_we) begin
            unique case (aabbxf_pkg::t_cfg_idx'(i_cfg_idx))
                aabbxf_pkg::CFG_XROW_XY: r_xrow_xy <= i_cfg_data;
                aabbxf_pkg::CFG_XROW_ZT: r_xrow_zt <= i_cfg_data;
                aabbxf_pkg::CFG_YROW_XY: r_yrow_xy <= i_cfg_data;
                aabbxf_pkg::CFG_YROW_ZT: r_yrow_zt <= i_cfg_data;
                aabbxf_pkg::CFG_ZROW_XY: r_zrow_xy <= i_cfg_data;
                aabbxf_pkg::CFG_ZROW_ZT: r_zrow_zt <= i_cfg_data;
                default: ;   // drop writes beyond the register list
            endcase
        end
    end

    // Coefficient view: [row][axis], translation per row
    aabbxf_pkg::t_coord coef [3][3];
    aabbxf_pkg::t_coord trans [3];

    always_comb begin
        coef[0][0] = r_xrow_xy[CW-1:0];
        coef[0][1] = r_xrow_xy[PW-1:CW];
        coef[0][2] = r_xrow_zt[CW-1:0];
        trans[0]   = r_xrow_zt[PW-1:CW];
        coef[1][0] = r_yrow_xy[CW-1:0];
        coef[1][1] = r_yrow_xy[PW-1:CW];
        coef[1][2] = r_yrow_zt[CW-1:0];
        trans[1]   = r_yrow_zt[PW-1:CW];
        coef[2][0] = r_zrow_xy[CW-1:0];
        coef[2][1] = r_zrow_xy[PW-1:CW];
        coef[2][2] = r_zrow_zt[CW-1:0];
        trans[2]   = r_zrow_zt[PW-1:CW];
    end

    // ---------------- pipeline flow control ----------------
    logic r_v0, r_v1, r_v2, r_v3, r_v4;
    logic rdy0, rdy1, rdy2, rdy3, rdy4;

    // A stage loads when it is empty or its content moves on
    assign rdy4 = !r_v4 || i_m_axis_tready;
    assign rdy3 = !r_v3 || rdy4;
    assign rdy2 = !r_v2 || rdy3;
    assign rdy1 = !r_v1 || rdy2;
    assign rdy0 = !r_v0 || rdy1;

    assign o_s_axis_tready = rdy0;
    assign o_m_axis_tvalid = r_v4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (rdy0) r_v0 <= i_s_axis_tvalid;
            if (rdy1) r_v1 <= r_v0;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
            if (rdy4) r_v4 <= r_v3;
        end
    end

    // ---------------- stage 0: input register ----------------
    aabbxf_pkg::t_coord r_in_lo [3];
    aabbxf_pkg::t_coord r_in_hi [3];

    always_ff @(posedge i_clk) begin
        if (rdy0 && i_s_axis_tvalid) begin
            for (int a = 0; a < 3; a++) begin
                r_in_lo[a] <= i_s_axis_tdata[a*CW +: CW];
                r_in_hi[a] <= i_s_axis_tdata[(a+3)*CW +: CW];
            end
        end
    end

    // ---------------- stage 1: widen flat axes ----------------
    aabbxf_pkg::t_coord n_lo [3];
    aabbxf_pkg::t_coord n_hi [3];
    aabbxf_pkg::t_coord r_lo [3];
    aabbxf_pkg::t_coord r_hi [3];

    always_comb begin
        logic signed [CW:0] diff, mag, hi_e, lo_e;
        for (int a = 0; a < 3; a++) begin
            diff = (CW+1)'(r_in_hi[a]) - (CW+1)'(r_in_lo[a]);
            mag  = diff[CW] ? -diff : diff;
            hi_e = (CW+1)'(r_in_hi[a]) + BIAS_E;
            lo_e = (CW+1)'(r_in_lo[a]) - BIAS_E;
            n_hi[a] = r_in_hi[a];
            n_lo[a] = r_in_lo[a];
            if (mag < BIAS_E) begin
                // saturate where the widened bound leaves the 32-bit range
                if (hi_e[CW] != hi_e[CW-1]) n_hi[a] = hi_e[CW] ? S32_MIN : S32_MAX;
                else                        n_hi[a] = hi_e[CW-1:0];
                if (lo_e[CW] != lo_e[CW-1]) n_lo[a] = lo_e[CW] ? S32_MIN : S32_MAX;
                else                        n_lo[a] = lo_e[CW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1 && r_v0) begin
            r_lo <= n_lo;
            r_hi <= n_hi;
        end
    end

    // ---------------- stage 2: products ----------------
    logic signed [PW-1:0] r_p_lo [3][3];
    logic signed [PW-1:0] r_p_hi [3][3];

    always_ff @(posedge i_clk) begin
        if (rdy2 && r_v1) begin
            for (int r = 0; r < 3; r++) begin
                for (int a = 0; a < 3; a++) begin
                    r_p_lo[r][a] <= coef[r][a] * r_lo[a];
                    r_p_hi[r][a] <= coef[r][a] * r_hi[a];
                end
            end
        end
    end

    // ---------------- stage 3: floor shift, per-axis min and max ----------------
    logic signed [SH_W-1:0] r_t_min [3][3];
    logic signed [SH_W-1:0] r_t_max [3][3];

    always_ff @(posedge i_clk) begin
        logic signed [PW-1:0]   s_lo, s_hi;
        logic signed [SH_W-1:0] t_lo, t_hi;
        if (rdy3 && r_v2) begin
            for (int r = 0; r < 3; r++) begin
                for (int a = 0; a < 3; a++) begin
                    s_lo = r_p_lo[r][a] >>> FRAC_BITS;
                    s_hi = r_p_hi[r][a] >>> FRAC_BITS;
                    t_lo = s_lo[SH_W-1:0];
                    t_hi = s_hi[SH_W-1:0];
                    r_t_min[r][a] <= (t_lo < t_hi) ? t_lo : t_hi;
                    r_t_max[r][a] <= (t_lo < t_hi) ? t_hi : t_lo;
                end
            end
        end
    end

    // ---------------- stage 4: sum, saturate, output register ----------------
    aabbxf_pkg::t_coord n_out_min [3];
    aabbxf_pkg::t_coord n_out_max [3];
    aabbxf_pkg::t_coord r_out_min [3];
    aabbxf_pkg::t_coord r_out_max [3];

    always_comb begin
        logic signed [SUM_W-1:0] s_min, s_max;
        for (int r = 0; r < 3; r++) begin
            s_min = SUM_W'(r_t_min[r][0]) + SUM_W'(r_t_min[r][1])
                  + SUM_W'(r_t_min[r][2]) + SUM_W'(trans[r]);
            s_max = SUM_W'(r_t_max[r][0]) + SUM_W'(r_t_max[r][1])
                  + SUM_W'(r_t_max[r][2]) + SUM_W'(trans[r]);
            if ((&s_min[SUM_W-1:CW-1]) || !(|s_min[SUM_W-1:CW-1]))
                n_out_min[r] = s_min[CW-1:0];
            else
                n_out_min[r] = s_min[SUM_W-1] ? S32_MIN : S32_MAX;
            if ((&s_max[SUM_W-1:CW-1]) || !(|s_max[SUM_W-1:CW-1]))
                n_out_max[r] = s_max[CW-1:0];
            else
                n_out_max[r] = s_max[SUM_W-1] ? S32_MIN : S32_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy4 && r_v3) begin
            r_out_min <= n_out_min;
            r_out_max <= n_out_max;
        end
    end

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            o_m_axis_tdata[a*CW +: CW]     = r_out_min[a];
            o_m_axis_tdata[(a+3)*CW +: CW] = r_out_max[a];
        end
    end

endmodule
